/* rtl/core/cpfla_pkg.sv */
// cpfla_pkg: shared constants, payload structs and codes for the chunk pool allocator
// no dependencies; used by cpfla_ctrl, cpfla_dp and chunk_pool_free_list_allocator
package cpfla_pkg;

	localparam int MAX_CHUNKS = 1024;
	localparam int IDX_W      = $clog2(MAX_CHUNKS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int CB_W       = 17;
	localparam int OFF_W      = 26;
	localparam int CFG_W      = (CNT_W > CB_W) ? CNT_W : CB_W;
	localparam int CFG_IDX_W  = 2;

	// null link marker is the chunk count itself
	localparam logic [CNT_W-1:0] NULL_MARK  = CNT_W'(MAX_CHUNKS);
	localparam logic [CNT_W-1:0] TOTAL_RST  = CNT_W'(MAX_CHUNKS);
	localparam logic [CB_W-1:0]  CBYTES_RST = CB_W'(64);

	// safe level floor(total*9/10) by reciprocal multiply
	localparam int SAFE_N = CNT_W + 4;
	localparam int SAFE_S = SAFE_N + 4;
	localparam int SAFE_K_W = SAFE_S - 2;
	localparam longint unsigned SAFE_K_VAL = ((64'd1 << SAFE_S) + 64'd9) / 64'd10;
	localparam logic [SAFE_K_W-1:0] SAFE_K = SAFE_K_W'(SAFE_K_VAL);
	localparam logic [CNT_W-1:0] SAFE_RST = CNT_W'((MAX_CHUNKS * 9) / 10);

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOTAL_CHUNKS = 2'd0,
		REG_CHUNK_BYTES  = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] chunk_index;
	} req_item_t;

	typedef struct packed {
		status_t          status;
		logic [IDX_W-1:0] granted_index;
		logic [OFF_W-1:0] byte_offset;
		logic [CNT_W-1:0] free_count;
		logic [CNT_W-1:0] danger_excess;
	} rsp_item_t;

	// one free-list memory entry: run length and link to next run head
	typedef struct packed {
		logic [CNT_W-1:0] run_len;
		logic [CNT_W-1:0] link;
	} run_entry_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} dp_cmd_t;

endpackage

/* rtl/core/chunk_pool_free_list_allocator.sv */
// chunk_pool_free_list_allocator: top level of the fixed-size chunk pool allocator
// depends on cpfla_pkg, cpfla_ctrl and cpfla_dp
//
// Hands out and takes back fixed-size chunks by index. Free chunks form a linked
// list of runs kept in a 1024-entry single-port memory; each run head holds its
// length and the next run head. Every transaction has a read step, reading the head
// run's entry from the memory, then an update step, updating head, count and memory
// and loading the result register. A new request transaction is taken only after
// the last one's update, which waits while the result register is full; a finished
// response may sit waiting while the next request is taken.
// No clearing pass is needed after reset or a total_chunks write: the initial single
// run is held as a flag, and every other entry is written before it is ever read.
// Configuration is accepted at any time but should only be written while idle.
module chunk_pool_free_list_allocator (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write transaction
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cpfla_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cpfla_pkg::CFG_W-1:0]     cfg_data,
	// request transaction: allocate or free
	input  logic                            req_valid,
	output logic                            req_ready,
	input  cpfla_pkg::req_item_t            req_data,
	// response transaction, one per request
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output cpfla_pkg::rsp_item_t            rsp_data
);

	cpfla_pkg::dp_cmd_t cmd;
	logic               cfg_we;

	// register writes go straight into the registers, so the port never stalls
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// sequencer: request capture, then update once the result register is free
	cpfla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	// datapath: free-list memory, pool state, config and result register
	cpfla_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_data  (req_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_data  (rsp_data)
	);

endmodule

/* rtl/core/cpfla_ctrl.sv */
// cpfla_ctrl: sequencer for the chunk pool allocator, read cycle then update cycle
// depends on cpfla_pkg
module cpfla_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output cpfla_pkg::dp_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   exec_go;

	assign req_ready   = (state_q == ST_IDLE);
	// result register may be refilled in the cycle it is emptied
	assign exec_go     = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_ready);
	assign cmd.capture = req_valid && req_ready;
	assign cmd.execute = exec_go;
	assign rsp_valid   = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (exec_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/cpfla_dp.sv */
// cpfla_dp: free-list memory, head and count registers, config registers, result register
// depends on cpfla_pkg
module cpfla_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cpfla_pkg::dp_cmd_t           cmd,
	input  cpfla_pkg::req_item_t         req_data,
	input  logic                         cfg_we,
	input  logic [cpfla_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cpfla_pkg::CFG_W-1:0]  cfg_data,
	output cpfla_pkg::rsp_item_t         rsp_data
);

	localparam int CNT_W = cpfla_pkg::CNT_W;
	localparam int IDX_W = cpfla_pkg::IDX_W;
	localparam int CB_W  = cpfla_pkg::CB_W;
	localparam int MUL_W = CNT_W + 7;
	localparam int SP_W  = cpfla_pkg::SAFE_N + cpfla_pkg::SAFE_K_W;

	cpfla_pkg::run_entry_t mem [cpfla_pkg::MAX_CHUNKS];

	logic [CNT_W-1:0] total_q;
	logic [CB_W-1:0]  cbytes_q;
	logic [CNT_W-1:0] safe_q;
	logic [CNT_W-1:0] head_q;
	logic [CNT_W-1:0] free_q;
	logic             init_q;
	cpfla_pkg::op_t   op_q;
	logic [IDX_W-1:0] idx_q;
	cpfla_pkg::run_entry_t rd_q;
	cpfla_pkg::rsp_item_t  rsp_q;

	// config path
	logic [CNT_W-1:0]            cfg_total;
	logic [cpfla_pkg::SAFE_N-1:0] cfg_total9;
	logic [SP_W-1:0]             cfg_safe_prod;

	always_comb begin
		cfg_total = cfg_data[CNT_W-1:0];
		if (cfg_total == '0) begin
			cfg_total = CNT_W'(1);
		end else if (cfg_total > cpfla_pkg::TOTAL_RST) begin
			cfg_total = cpfla_pkg::TOTAL_RST;
		end
		cfg_total9    = (cpfla_pkg::SAFE_N'(cfg_total) << 3) + cpfla_pkg::SAFE_N'(cfg_total);
		cfg_safe_prod = SP_W'(cfg_total9) * SP_W'(cpfla_pkg::SAFE_K);
	end

	// update path
	logic [CNT_W-1:0]      run_len, run_rem, link, head_nxt, free_nxt, head_inc, used;
	logic                  alloc_ok, free_ok, split, danger_hit, mem_we;
	logic [IDX_W-1:0]      waddr, granted;
	cpfla_pkg::run_entry_t wdata;
	cpfla_pkg::status_t    status;
	logic [IDX_W+CB_W-1:0] offset_prod;
	logic [MUL_W-1:0]      used100, total95;

	always_comb begin
		run_len  = (init_q && head_q == '0) ? total_q : rd_q.run_len;
		link     = (init_q && head_q == '0) ? cpfla_pkg::NULL_MARK : rd_q.link;
		run_rem  = (run_len == '0) ? '0 : run_len - CNT_W'(1);
		head_inc = head_q + CNT_W'(1);
		split    = (run_rem != '0) && (head_inc < total_q);
		alloc_ok = (free_q != '0) && (head_q < total_q);
		free_ok  = ({1'b0, idx_q} < total_q) && (free_q < total_q);

		head_nxt = head_q;
		free_nxt = free_q;
		mem_we   = 1'b0;
		waddr    = head_inc[IDX_W-1:0];
		wdata    = '{run_len: run_rem, link: link};
		granted  = '0;
		status   = cpfla_pkg::STATUS_OK;

		case (op_q)
			cpfla_pkg::OP_ALLOC: begin
				if (!alloc_ok) begin
					status = cpfla_pkg::STATUS_EMPTY;
				end else begin
					granted  = head_q[IDX_W-1:0];
					free_nxt = free_q - CNT_W'(1);
					if (split) begin
						mem_we   = 1'b1;
						head_nxt = head_inc;
					end else begin
						head_nxt = link;
					end
				end
			end
			cpfla_pkg::OP_FREE: begin
				waddr = idx_q;
				wdata = '{run_len: CNT_W'(1), link: head_q};
				if (!free_ok) begin
					status = cpfla_pkg::STATUS_RANGE;
				end else begin
					mem_we   = 1'b1;
					head_nxt = {1'b0, idx_q};
					free_nxt = free_q + CNT_W'(1);
				end
			end
			default: begin
				status = cpfla_pkg::STATUS_EMPTY;
			end
		endcase

		offset_prod = (IDX_W+CB_W)'(granted) * (IDX_W+CB_W)'(cbytes_q);
		used        = (free_nxt <= total_q) ? total_q - free_nxt : '0;
		// used > floor(total*95/100) is the same as used*100 > total*95
		used100     = MUL_W'(used) * MUL_W'(100);
		total95     = MUL_W'(total_q) * MUL_W'(95);
		danger_hit  = used100 > total95;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= cpfla_pkg::TOTAL_RST;
			cbytes_q <= cpfla_pkg::CBYTES_RST;
			safe_q   <= cpfla_pkg::SAFE_RST;
			head_q   <= '0;
			free_q   <= cpfla_pkg::TOTAL_RST;
			init_q   <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cpfla_pkg::REG_TOTAL_CHUNKS: begin
						total_q <= cfg_total;
						safe_q  <= cfg_safe_prod[cpfla_pkg::SAFE_S +: CNT_W];
						head_q  <= '0;
						free_q  <= cfg_total;
						init_q  <= 1'b1;
					end
					cpfla_pkg::REG_CHUNK_BYTES: begin
						cbytes_q <= cfg_data[CB_W-1:0];
					end
					default: begin
					end
				endcase
			end else if (cmd.execute) begin
				head_q <= head_nxt;
				free_q <= free_nxt;
				if (mem_we && waddr == '0) begin
					init_q <= 1'b0;
				end
			end
		end
	end

	// memory, operand and result registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= req_data.op;
			idx_q <= req_data.chunk_index;
			rd_q  <= mem[head_q[IDX_W-1:0]];
		end
		if (cmd.execute) begin
			if (mem_we) begin
				mem[waddr] <= wdata;
			end
			rsp_q.status        <= status;
			rsp_q.granted_index <= granted;
			rsp_q.byte_offset   <= cpfla_pkg::OFF_W'(offset_prod);
			rsp_q.free_count    <= free_nxt;
			rsp_q.danger_excess <= danger_hit ? used - safe_q : '0;
		end
	end

	assign rsp_data = rsp_q;

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for chunk_pool_free_list_allocator
// depends on cpfla_pkg and the allocator rtl; keeps its own copy of the free list of runs
// and checks every response transaction against it, directed table first, then random phases
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cpfla_pkg::*;

	localparam int RANDOM_ITEMS  = 1430;
	localparam int LONG_HOLD     = 300;
	localparam int QUIET_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 12;
	// a register index the block does not decode
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 req_valid;
	logic                 req_ready;
	req_item_t            req_data;
	logic                 rsp_valid;
	logic                 rsp_ready;
	rsp_item_t            rsp_data;

	chunk_pool_free_list_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	// shadow of the pool: configuration, head, count and the run memory
	logic [CNT_W-1:0] pool_total;
	logic [CB_W-1:0]  pool_cbytes;
	logic [CNT_W-1:0] pool_head;
	logic [CNT_W-1:0] pool_free;
	logic [CNT_W-1:0] run_len_m [MAX_CHUNKS];
	logic [CNT_W-1:0] link_m [MAX_CHUNKS];
	// chunks handed out and not yet given back, so that frees can be well formed
	logic [IDX_W-1:0] held_chunks [$];

	// responses still owed by the block, oldest first
	rsp_item_t owed_rsp [$];
	int        mismatches = 0;
	int        quiet_cycles = 0;

	// handed from the request driver to the monitor with each request transaction
	logic      typed_fixed;
	rsp_item_t typed_want;

	// idling controls, changed per phase
	int   send_gap_max = 15;
	int   recv_gap_max = 15;
	logic long_hold_ask = 1'b0;

	// directed table: configuration writes and requests, some with a typed-in answer
	typedef struct packed {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [CFG_W-1:0]     value;
		req_item_t            item;
		logic                 fixed;
		rsp_item_t            want;
	} script_row_t;

	script_row_t script [$];

	function automatic void add_cfg(logic [CFG_IDX_W-1:0] which, logic [CFG_W-1:0] value);
		script_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.reg_idx = which;
		row.value = value;
		script.push_back(row);
	endfunction

	function automatic void add_op(op_t op, logic [IDX_W-1:0] idx);
		script_row_t row;
		row = '0;
		row.item.op = op;
		row.item.chunk_index = idx;
		script.push_back(row);
	endfunction

	function automatic void add_chk(op_t op, logic [IDX_W-1:0] idx, status_t st, int granted,
			int offset, int free_n, int excess);
		add_op(op, idx);
		script[$].fixed = 1'b1;
		script[$].want = '{st, IDX_W'(granted), OFF_W'(offset), CNT_W'(free_n), CNT_W'(excess)};
	endfunction

	// one run covering the whole pool, nothing held
	function automatic void pool_reinit();
		for (int i = 0; i < MAX_CHUNKS; i++) begin
			run_len_m[i] = '0;
			link_m[i] = NULL_MARK;
		end
		pool_head = '0;
		pool_free = pool_total;
		run_len_m[0] = pool_total;
		held_chunks.delete();
	endfunction

	function automatic void pool_write_reg(logic [CFG_IDX_W-1:0] which, logic [CFG_W-1:0] value);
		logic [CNT_W-1:0] n;
		n = value[CNT_W-1:0];
		case (which)
		REG_TOTAL_CHUNKS: begin
			// clamp into 1..MAX_CHUNKS, then start the pool afresh
			if (n == 0)
				n = CNT_W'(1);
			if (n > MAX_CHUNKS)
				n = CNT_W'(MAX_CHUNKS);
			pool_total = n;
			pool_reinit();
		end
		REG_CHUNK_BYTES: pool_cbytes = value[CB_W-1:0];
		default: ;
		endcase
	endfunction

	// used beyond the 95 % mark is reported relative to the 90 % mark
	function automatic int unsigned excess_now();
		int unsigned t;
		int unsigned used;
		t = pool_total;
		used = (pool_free <= pool_total) ? t - pool_free : 0;
		if (used > (t * 95) / 100)
			return used - (t * 90) / 100;
		return 0;
	endfunction

	// applies one request transaction to the shadow pool and gives the answer
	function automatic rsp_item_t pool_step(req_item_t r);
		rsp_item_t   res;
		int unsigned h;
		int unsigned len;
		int unsigned rem;
		int unsigned lnk;
		logic [63:0] off;
		res = '0;
		res.status = STATUS_OK;
		if (r.op == OP_ALLOC) begin
			h = pool_head;
			// empty pool or a head off the end of the pool
			if (pool_free == 0 || h >= pool_total) begin
				res.status = STATUS_EMPTY;
			end else begin
				len = run_len_m[h];
				// a zero length at the head counts as one chunk
				rem = (len > 0) ? len - 1 : 0;
				lnk = link_m[h];
				if (rem > 0 && h + 1 < pool_total) begin
					run_len_m[h + 1] = CNT_W'(rem);
					link_m[h + 1] = CNT_W'(lnk);
					pool_head = CNT_W'(h + 1);
				end else begin
					pool_head = CNT_W'(lnk);
				end
				pool_free = pool_free - 1'b1;
				off = 64'(h) * 64'(pool_cbytes);
				res.granted_index = IDX_W'(h);
				res.byte_offset = off[OFF_W-1:0];
				held_chunks.push_back(IDX_W'(h));
			end
		end else begin
			// out of range, or nothing can be given back to a full pool
			if (r.chunk_index >= pool_total || pool_free >= pool_total) begin
				res.status = STATUS_RANGE;
			end else begin
				// double frees are not caught: the chunk is simply pushed again
				run_len_m[r.chunk_index] = CNT_W'(1);
				link_m[r.chunk_index] = pool_head;
				pool_head = {1'b0, r.chunk_index};
				pool_free = pool_free + 1'b1;
				for (int k = 0; k < held_chunks.size(); k++) begin
					if (held_chunks[k] == r.chunk_index) begin
						held_chunks.delete(k);
						break;
					end
				end
			end
		end
		res.free_count = pool_free;
		res.danger_excess = CNT_W'(excess_now());
		return res;
	endfunction

	function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	// clock, 4 ns period
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// monitor: everything is sampled at the rising edge, inputs move at the falling edge
	always @(posedge clk) begin : monitor
		rsp_item_t want;
		if (arst_n) begin
			// responses first: a request taken this edge cannot be answered at the same edge
			if (rsp_valid && rsp_ready) begin
				if (owed_rsp.size() == 0) begin
					mismatches++;
					$display("%0t: response transaction with none expected, got %h", $time, rsp_data);
				end else begin
					want = owed_rsp.pop_front();
					field_check("status", 32'(want.status), 32'(rsp_data.status));
					field_check("granted_index", 32'(want.granted_index),
						32'(rsp_data.granted_index));
					field_check("byte_offset", 32'(want.byte_offset), 32'(rsp_data.byte_offset));
					field_check("free_count", 32'(want.free_count), 32'(rsp_data.free_count));
					field_check("danger_excess", 32'(want.danger_excess),
						32'(rsp_data.danger_excess));
				end
			end
			if (req_valid && req_ready) begin
				// the shadow pool always moves on, a typed-in answer only replaces the expectation
				want = pool_step(req_data);
				if (typed_fixed)
					want = typed_want;
				owed_rsp.push_back(want);
			end
			if (cfg_valid && cfg_ready)
				pool_write_reg(cfg_index, cfg_data);
		end
	end

	// watchdog: too long without any transaction on any channel
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// response side: random hold-offs, now and then a long one to back the block up
	initial begin : response_side
		int hold;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			hold = $urandom_range(0, recv_gap_max);
			if (long_hold_ask) begin
				long_hold_ask = 1'b0;
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				rsp_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!(rsp_valid && rsp_ready));
		end
	end

	// the request driver starts just after a falling edge and returns at the accepting rising edge
	task automatic send_item(req_item_t item, logic fixed, rsp_item_t want);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= item;
		typed_fixed <= fixed;
		typed_want <= want;
		do @(posedge clk); while (!(req_valid && req_ready));
	endtask

	// stop offering requests and wait for every owed response
	task automatic drain();
		req_valid <= 1'b0;
		while (owed_rsp.size() != 0) @(negedge clk);
	endtask

	// register writes only with the block idle
	task automatic write_reg(logic [CFG_IDX_W-1:0] which, logic [CFG_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		req_item_t        item;
		int               roll;
		int               alloc_pct;
		int               phase_len;
		int               random_sent;
		int               phase;
		logic [CFG_W-1:0] pick;

		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		typed_fixed = 1'b0;
		typed_want = '0;
		pool_total = TOTAL_RST;
		pool_cbytes = CBYTES_RST;
		pool_reinit();

		// reset state: 1024 chunks of 64 bytes in one run
		add_chk(OP_ALLOC, 10'd1023, STATUS_OK, 0, 0, 1023, 0);
		add_chk(OP_ALLOC, 10'd0, STATUS_OK, 1, 64, 1022, 0);
		// free a chunk that is still free inside the run, then fill the pool back up
		add_chk(OP_FREE, 10'd1023, STATUS_OK, 0, 0, 1023, 0);
		add_chk(OP_FREE, 10'd0, STATUS_OK, 0, 0, 1024, 0);
		// free into a full pool
		add_chk(OP_FREE, 10'd5, STATUS_RANGE, 0, 0, 1024, 0);
		add_chk(OP_ALLOC, 10'd0, STATUS_OK, 0, 0, 1023, 0);
		// largest chunk size, offset wraps at 26 bits
		add_cfg(REG_CHUNK_BYTES, 17'h1FFFF);
		add_op(OP_ALLOC, 10'd0);
		// pool size of zero clamps to a single chunk
		add_cfg(REG_TOTAL_CHUNKS, 17'd0);
		add_chk(OP_FREE, 10'd0, STATUS_RANGE, 0, 0, 1, 0);
		add_chk(OP_ALLOC, 10'd0, STATUS_OK, 0, 0, 0, 1);
		add_chk(OP_ALLOC, 10'd0, STATUS_EMPTY, 0, 0, 0, 1);
		add_chk(OP_FREE, 10'd1023, STATUS_RANGE, 0, 0, 0, 1);
		add_chk(OP_FREE, 10'd0, STATUS_OK, 0, 0, 1, 0);
		// undecoded index is dropped, oversized pool clamps to the maximum
		add_cfg(REG_UNUSED, 17'h1FFFF);
		add_cfg(REG_TOTAL_CHUNKS, 17'h1FFFF);
		add_cfg(REG_CHUNK_BYTES, 17'd4);
		add_chk(OP_ALLOC, 10'd0, STATUS_OK, 0, 0, 1023, 0);
		add_chk(OP_ALLOC, 10'd1023, STATUS_OK, 1, 4, 1022, 0);
		// two chunks: danger and safe levels are both one
		add_cfg(REG_TOTAL_CHUNKS, 17'd2);
		add_chk(OP_ALLOC, 10'd0, STATUS_OK, 0, 0, 1, 0);
		add_chk(OP_ALLOC, 10'd0, STATUS_OK, 1, 4, 0, 1);
		add_chk(OP_ALLOC, 10'd0, STATUS_EMPTY, 0, 0, 0, 1);
		add_chk(OP_FREE, 10'd1, STATUS_OK, 0, 0, 1, 0);
		// double free of the same chunk, list now loops on itself
		add_chk(OP_FREE, 10'd1, STATUS_OK, 0, 0, 2, 0);
		add_op(OP_ALLOC, 10'd0);
		add_op(OP_ALLOC, 10'd0);
		add_op(OP_FREE, 10'd2);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (script[n]) begin
			@(negedge clk);
			if (script[n].is_cfg)
				write_reg(script[n].reg_idx, script[n].value);
			else
				send_item(script[n].item, script[n].fixed, script[n].want);
		end

		// random phases, each on a fresh pool setting
		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			@(negedge clk);
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 7))
				0: pick = '0;
				1: pick = '1;
				2: pick = 17'd4;
				3: pick = 17'd65536;
				default: pick = CFG_W'($urandom_range(0, 17'h1FFFF));
				endcase
				write_reg(REG_CHUNK_BYTES, pick);
				@(negedge clk);
			end
			case ($urandom_range(0, 9))
			0: pick = '0;
			1: pick = 17'd1;
			2: pick = 17'd1024;
			3: pick = CFG_W'($urandom_range(1025, 17'h1FFFF));
			default: pick = CFG_W'($urandom_range(2, 40));
			endcase
			write_reg(REG_TOTAL_CHUNKS, pick);
			if ($urandom_range(0, 7) == 0) begin
				@(negedge clk);
				write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 17'h1FFFF)));
			end

			// enough traffic to walk a small pool to empty and back several times
			phase_len = pool_total * 3 + $urandom_range(8, 40);
			if (phase_len > 240)
				phase_len = 240;
			if (phase_len > RANDOM_ITEMS - random_sent)
				phase_len = RANDOM_ITEMS - random_sent;
			alloc_pct = $urandom_range(30, 75);
			send_gap_max = $urandom_range(0, 1) ? 15 : 0;
			recv_gap_max = $urandom_range(0, 1) ? 15 : 0;
			// long response hold-off with the request side flat out, block must stall
			if (phase == 1 || $urandom_range(0, 9) == 0) begin
				long_hold_ask = 1'b1;
				send_gap_max = 0;
			end

			repeat (phase_len) begin
				@(negedge clk);
				roll = $urandom_range(0, 99);
				item.chunk_index = IDX_W'($urandom_range(0, MAX_CHUNKS - 1));
				if (roll < alloc_pct) begin
					item.op = OP_ALLOC;
				end else begin
					item.op = OP_FREE;
					// mostly give back something held, else a chunk of the pool or any index
					if (roll < 92 && held_chunks.size() > 0)
						item.chunk_index = held_chunks[$urandom_range(0, held_chunks.size() - 1)];
					else if (roll < 96)
						item.chunk_index = IDX_W'($urandom_range(0, pool_total - 1));
				end
				send_item(item, 1'b0, '0);
				random_sent++;
			end
			phase++;
		end

		@(negedge clk);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && owed_rsp.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
